[rtl/wtv_pkg.sv]
// ----------------------------------------------------------------------------
// wtv_pkg
// Shared types and constants for the wavetable voice with exponential release.
// ----------------------------------------------------------------------------
package wtv_pkg;

  // Default geometry of the voice.
  localparam int unsigned TableDepthDef  = 1024;
  localparam int unsigned SampleWidthDef = 24;

  // Fixed field widths.
  localparam int unsigned FuncW      = 2;
  localparam int unsigned TableIdxW  = 10;
  localparam int unsigned WordW      = 24;
  localparam int unsigned PhaseW     = 32;
  localparam int unsigned FracBits   = 22;
  localparam int unsigned GainW      = 16;
  localparam int unsigned EnvW       = 16;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 16;

  // Width used for table address arithmetic (covers depths up to 4096).
  localparam int unsigned ModW       = 16;

  // Envelope value that stands for unity gain, Q1.15.
  localparam logic [EnvW:0] EnvOne   = 17'd32768;

  // Register reset values.
  localparam logic [CfgDataW-1:0] DecayRst = 16'd64881;
  localparam logic [CfgDataW-1:0] FloorRst = 16'd164;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_DECAY = 1'b0,
    REG_FLOOR = 1'b1
  } wtv_reg_e;

  // Request function codes.
  typedef enum logic [FuncW-1:0] {
    FUNC_LOAD     = 2'd0,
    FUNC_NOTE_ON  = 2'd1,
    FUNC_NOTE_OFF = 2'd2,
    FUNC_TICK     = 2'd3
  } wtv_func_e;

  // Sequencer states for one sample tick.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DONE
  } wtv_state_e;

endpackage

[rtl/wtv_ram.sv]
// ----------------------------------------------------------------------------
// wtv_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module wtv_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/wavetable_voice_with_release_top.sv]
// ----------------------------------------------------------------------------
// wavetable_voice_with_release_top
// Single wavetable oscillator voice with an exponential release envelope.
// ----------------------------------------------------------------------------
// Table loads, note on and note off produce no result. A sample tick runs
// through table read, gain multiply, envelope multiply, then round and
// saturate into the output register; new requests stall until it is done.
// The output register lets the next request enter while a result still waits.
// Reset clears the voice state and puts the configuration registers to their
// reset values; the wavetable itself is not cleared and holds garbage until loaded.
module wavetable_voice_with_release_top
  import wtv_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = TableDepthDef,
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write port.
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  // Request channel.
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [FuncW-1:0]        func_i,
  input  logic [TableIdxW-1:0]    table_index_i,
  input  logic [WordW-1:0]        table_word_i,
  input  logic [PhaseW-1:0]       phase_step_i,
  input  logic [GainW-1:0]        note_gain_i,
  input  logic                    allow_tail_i,
  // Result channel.
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                    voice_active_o
);

  localparam int unsigned AddrW  = $clog2(TABLE_DEPTH);
  localparam int unsigned Prod1W = WordW + GainW + 1;
  localparam int unsigned Prod2W = Prod1W + EnvW + 1;
  localparam int unsigned RoundW = Prod2W - 31;
  localparam logic signed [63:0] SatHi = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] SatLo = -SatHi - 64'sd1;

  // Configuration registers.
  logic [CfgDataW-1:0] decay_q, floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= DecayRst;
      floor_q <= FloorRst;
    end else if (cfg_we_i) begin
      case (wtv_reg_e'(cfg_index_i))
        REG_DECAY: decay_q <= cfg_data_i;
        REG_FLOOR: floor_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // Voice state.
  wtv_state_e        state_q, state_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [PhaseW-1:0] step_q, step_d;
  logic [GainW-1:0]  gain_q, gain_d;
  logic [EnvW-1:0]   env_q, env_d;
  logic              active_q, active_d;

  // Tick pipeline registers.
  logic                     tick_act_q, tick_act_d;
  logic [EnvW:0]            env_mul_q, env_mul_d;
  logic signed [Prod1W-1:0] prod1_q;
  logic signed [Prod2W-1:0] prod2_q;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  logic [SAMPLE_WIDTH-1:0] sample_q;
  logic                    voice_q;
  logic                    out_load;

  logic        in_accept;
  wtv_func_e   func;
  logic [WordW-1:0] ram_rdata;
  logic        ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [ModW-1:0]  load_idx;
  logic [ModW-1:0]  rd_idx;
  logic [2*EnvW-1:0] env_prod;
  logic [EnvW-1:0]   env_next;

  assign func      = wtv_func_e'(func_i);
  assign in_accept = in_valid_i && !in_stall_o;

  // Load address: words beyond the table are dropped.
  assign load_idx  = ModW'(table_index_i);
  assign ram_we    = in_accept && (func == FUNC_LOAD) && (load_idx < ModW'(TABLE_DEPTH));
  assign ram_waddr = load_idx[AddrW-1:0];

  // Read address: rounded-up integer phase, reduced modulo the table depth by
  // four conditional subtractions (the value is at most 1024, under sixteen depths when the depth exceeds 64).
  always_comb begin
    rd_idx = ModW'(phase_q[PhaseW-1:FracBits]) + ModW'(|phase_q[FracBits-1:0]);
    for (int k = 3; k >= 0; k--) begin
      if (rd_idx >= ModW'(TABLE_DEPTH << k)) begin
        rd_idx = rd_idx - ModW'(TABLE_DEPTH << k);
      end
    end
  end

  assign ram_raddr = rd_idx[AddrW-1:0];
  assign ram_re    = in_accept && (func == FUNC_TICK);

  wtv_ram #(
    .WIDTH (WordW),
    .DEPTH (TABLE_DEPTH)
  ) u_wave_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (table_word_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Release envelope decay for one sample.
  assign env_prod = env_q * decay_q;
  assign env_next = env_prod[2*EnvW-1:EnvW];

  // Rounding and saturation of the final product.
  logic signed [RoundW-1:0] rounded;
  logic signed [63:0]       rounded_ext;
  logic [SAMPLE_WIDTH-1:0]  sat_val;

  always_comb begin
    logic signed [Prod2W-1:0] biased;
    biased      = prod2_q + (Prod2W'(1) <<< 30);
    rounded     = biased[Prod2W-1:31];
    rounded_ext = 64'(rounded);
    if (rounded_ext > SatHi) begin
      sat_val = SatHi[SAMPLE_WIDTH-1:0];
    end else if (rounded_ext < SatLo) begin
      sat_val = SatLo[SAMPLE_WIDTH-1:0];
    end else begin
      sat_val = rounded_ext[SAMPLE_WIDTH-1:0];
    end
  end

  // Sequencer: request decode, state update and tick stepping.
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    step_d     = step_q;
    gain_d     = gain_q;
    env_d      = env_q;
    active_d   = active_q;
    tick_act_d = tick_act_q;
    env_mul_d  = env_mul_q;
    out_load   = 1'b0;
    in_stall_o = 1'b1;

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (func)
            FUNC_LOAD: ;
            FUNC_NOTE_ON: begin
              step_d   = phase_step_i;
              gain_d   = note_gain_i;
              phase_d  = '0;
              env_d    = '0;
              active_d = 1'b1;
            end
            FUNC_NOTE_OFF: begin
              if (active_q) begin
                if (allow_tail_i) begin
                  if (env_q == '0) begin
                    env_d = EnvOne[EnvW-1:0];
                  end
                end else begin
                  active_d = 1'b0;
                  env_d    = '0;
                end
              end
            end
            FUNC_TICK: begin
              // Latch what the sample needs, then step the voice right away.
              tick_act_d = active_q;
              env_mul_d  = (env_q != '0) ? {1'b0, env_q} : EnvOne;
              state_d    = ST_READ;
              if (active_q) begin
                phase_d = phase_q + step_q;
                if (env_q != '0) begin
                  if (env_next <= floor_q) begin
                    env_d    = '0;
                    active_d = 1'b0;
                  end else begin
                    env_d = env_next;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: state_d = ST_MUL;
      ST_MUL:  state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= '0;
      step_q     <= '0;
      gain_q     <= '0;
      env_q      <= '0;
      active_q   <= 1'b0;
      tick_act_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      step_q     <= step_d;
      gain_q     <= gain_d;
      env_q      <= env_d;
      active_q   <= active_d;
      tick_act_q <= tick_act_d;
    end
  end

  // Multiply chain: table word by gain, then by the envelope.
  always_ff @(posedge clk_i) begin
    env_mul_q <= env_mul_d;
    if (state_q == ST_READ) begin
      prod1_q <= $signed(ram_rdata) * $signed({1'b0, gain_q});
    end
    if (state_q == ST_MUL) begin
      prod2_q <= prod1_q * $signed(env_mul_q);
    end
  end

  // Output register; an idle voice gives silence.
  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_q <= tick_act_q ? sat_val : '0;
      voice_q  <= tick_act_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = sample_q;
  assign voice_active_o = voice_q;

endmodule
